/* hdl/piecewise_linear_interp_top_macros.svh */
// Assertion macros for the piecewise linear interpolator.
// Used by piecewise_linear_interp_top; needs clk and rst_n in scope.
`ifndef PIECEWISE_LINEAR_INTERP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERP_TOP_MACROS_SVH
`ifndef SYNTH
`define PLI_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define PLI_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PLI_ASSERT_IMP(lbl, a, b)
`define PLI_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* hdl/pli_pkg.sv */
// Shared constants for the piecewise linear interpolator.
// No dependencies; used by the top level and the testbench.
package pli_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int REG_SOURCE_COUNT = 0;
  localparam logic [6:0] COUNT_RESET = 7'd2;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
endpackage

/* hdl/pli_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on nothing but plain logic types.
interface pli_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         point_index;
  logic signed [31:0] coord;
  logic signed [31:0] value;
  modport source (output valid, kind, point_index, coord, value, input ready);
  modport sink   (input valid, kind, point_index, coord, value, output ready);
endinterface

interface pli_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic               saturated;
  modport source (output valid, interp_value, saturated, input ready);
  modport sink   (input valid, interp_value, saturated, output ready);
endinterface

/* hdl/piecewise_linear_interp_top.sv */
// Top level of the piecewise linear interpolator: grid memories, search and
// interpolation sequencer, APB register port. Uses pli_pkg, pli_if.sv and
// the assertion macro header.
//
// The block keeps a grid of up to MAX_POINTS (x, y) pairs in two synchronous
// memories, each with a write port and a registered read port. A load
// request writes one pair. A query request runs a binary search over the
// active points: each probe passes through ST_SRCH and ST_SCMP, there are at
// most ceil(log2(n+1)) probes, and a final ST_SRCH sees the search end. The
// block then reads the two bracketing entries (ST_BRL, ST_BRR), forms the
// differences (ST_CALC) and one 33x33 product (ST_MUL). After that it divides
// with a restoring divider that retires one quotient bit per cycle. The sum
// and its saturation are formed on the last divide step. When the two
// bracketing coordinates are equal, the product and the division are
// skipped. The result then waits in the output register until taken, and a
// new request is accepted after that. source_count is clamped to the range
// 2..MAX_POINTS; slots that were never loaded read as garbage.
`include "piecewise_linear_interp_top_macros.svh"
module piecewise_linear_interp_top #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pli_req_if.sink                         in_req,
  pli_res_if.source                       out_res,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pli_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pli_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pli_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import pli_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = (CW > 7) ? CW : 7;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SRCH = 9'b000000010,
    ST_SCMP = 9'b000000100,
    ST_BRL  = 9'b000001000,
    ST_BRR  = 9'b000010000,
    ST_CALC = 9'b000100000,
    ST_MUL  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Register port. Register 0 is source_count; address bit 2 selects
  // beyond the register list.
  logic [6:0] source_count_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == 1'b0) begin
      cfg_prdata = {{(CFG_DATA_W-7){1'b0}}, source_count_r};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_count_r <= COUNT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      source_count_r <= cfg_pwdata[6:0];
    end
  end

  // Active point count, clamped to 2..MAX_POINTS.
  logic [EW-1:0] cnt_e;
  logic [CW-1:0] n_act;
  always_comb begin
    cnt_e = EW'(source_count_r);
    if (cnt_e < EW'(2)) begin
      n_act = CW'(2);
    end else if (cnt_e > EW'(MAX_POINTS)) begin
      n_act = CW'(MAX_POINTS);
    end else begin
      n_act = CW'(cnt_e);
    end
  end

  // Grid memories: write on load, registered read at a separate address.
  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [AW-1:0]      rd_addr;
  logic               in_acc, load_wr;
  assign in_acc  = in_req.valid && in_req.ready;
  assign load_wr = in_acc && (in_req.kind == KIND_LOAD) &&
                   (32'(in_req.point_index) < MAX_POINTS);
  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem_x[AW'(in_req.point_index)] <= in_req.coord;
      mem_y[AW'(in_req.point_index)] <= in_req.value;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // Query datapath registers.
  logic signed [31:0] xq_r;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0]      right_c;
  logic signed [31:0] xlo_r, ylo_r;
  logic [32:0]        mdx_r, mdy_r, mdt_r;
  logic               neg_r;
  logic [63:0]        quo_r;
  logic [32:0]        rem_r;
  logic [5:0]         bit_r;
  logic signed [31:0] res_r;
  logic               sat_r;

  always_comb begin
    right_c = lo_r;
    if (right_c < CW'(1)) begin
      right_c = CW'(1);
    end
    if (right_c > n_act - CW'(1)) begin
      right_c = n_act - CW'(1);
    end
  end

  // The left bracket is addressed in ST_BRL and captured in ST_BRR; the
  // right bracket is addressed in ST_BRR and used in ST_CALC.
  always_comb begin
    mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
    rd_addr = AW'(mid_nxt);
    case (state_r)
      ST_SRCH: rd_addr = AW'(mid_nxt);
      ST_BRL:  rd_addr = AW'(right_c - CW'(1));
      ST_BRR:  rd_addr = AW'(right_c);
      default: rd_addr = AW'(mid_nxt);
    endcase
  end

  // Search step: lo/hi update once the probed coordinate is back.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (rd_x_r < xq_r) begin
      lo_nxt = mid_r + CW'(1);
    end else begin
      hi_nxt = mid_r;
    end
  end

  // Differences from the right bracket as it arrives; magnitudes are registered in ST_CALC.
  logic signed [32:0] dx_c, dy_c, dt_c;
  assign dx_c = {rd_x_r[31], rd_x_r} - {xlo_r[31], xlo_r};
  assign dy_c = {rd_y_r[31], rd_y_r} - {ylo_r[31], ylo_r};
  assign dt_c = {xq_r[31], xq_r} - {xlo_r[31], xlo_r};

  // One restoring division step.
  logic [33:0] rem_s;
  logic        q_bit;
  always_comb begin
    rem_s = {rem_r, quo_r[63]};
    q_bit = (rem_s >= {1'b0, mdx_r});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && (in_req.kind == KIND_QUERY)) state_nxt = ST_SRCH;
      ST_SRCH: state_nxt = (lo_r < hi_r) ? ST_SCMP : ST_BRL;
      ST_SCMP: state_nxt = ST_SRCH;
      ST_BRL:  state_nxt = ST_BRR;
      ST_BRR:  state_nxt = ST_CALC;
      ST_CALC: state_nxt = (dx_c == 33'sd0) ? ST_OUT : ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (bit_r == 6'd0) state_nxt = ST_OUT;
      ST_OUT:  if (out_res.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The last division step hands off straight to the result register.
  logic [63:0] quo_fin;
  assign quo_fin = {quo_r[62:0], q_bit};

  // Final sum with saturation, on the completed quotient.
  logic signed [41:0] sum_fin;
  logic               sat_fin;
  always_comb begin
    if (neg_r) begin
      sum_fin = {{10{ylo_r[31]}}, ylo_r} - $signed({1'b0, quo_fin[40:0]});
    end else begin
      sum_fin = {{10{ylo_r[31]}}, ylo_r} + $signed({1'b0, quo_fin[40:0]});
    end
    sat_fin = (sum_fin > 42'sd2147483647) || (sum_fin < -42'sd2147483648);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        xq_r <= in_req.coord;
        lo_r <= '0;
        hi_r <= n_act;
      end
      ST_SRCH: mid_r <= mid_nxt;
      ST_SCMP: begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
      end
      ST_BRR: begin
        xlo_r <= rd_x_r;
        ylo_r <= rd_y_r;
      end
      ST_CALC: begin
        mdx_r <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        mdy_r <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
        mdt_r <= dt_c[32] ? 33'(-dt_c) : 33'(dt_c);
        neg_r <= (dx_c[32] != dy_c[32]) != dt_c[32];
        res_r <= ylo_r;
        sat_r <= 1'b0;
      end
      ST_MUL: begin
        quo_r <= 64'({33'd0, mdy_r} * {33'd0, mdt_r});
        rem_r <= '0;
        bit_r <= 6'd63;
      end
      ST_DIV: begin
        quo_r <= quo_fin;
        rem_r <= q_bit ? 33'(rem_s - {1'b0, mdx_r}) : rem_s[32:0];
        bit_r <= bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          // Quotient complete; quo_r is stale here, so the sum uses quo_fin.
          if (|quo_fin[63:40]) begin
            sat_r <= 1'b1;
            res_r <= neg_r ? 32'sh80000000 : 32'sh7fffffff;
          end else begin
            sat_r <= sat_fin;
            if (sum_fin > 42'sd2147483647) begin
              res_r <= 32'sh7fffffff;
            end else if (sum_fin < -42'sd2147483648) begin
              res_r <= 32'sh80000000;
            end else begin
              res_r <= 32'(sum_fin);
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_res.valid        = (state_r == ST_OUT);
  assign out_res.interp_value = res_r;
  assign out_res.saturated    = sat_r;

  // A saturated result is always one of the two range limits.
  `PLI_ASSERT_IMP(a_sat_limit, out_res.valid && out_res.saturated,
    (out_res.interp_value == 32'sh7fffffff) || (out_res.interp_value == 32'sh80000000))
  // The search window never leaves the active grid.
  `PLI_ASSERT_IMP(a_hi_bound, (state_r == ST_SRCH) || (state_r == ST_SCMP),
    (hi_r <= n_act) && (lo_r <= hi_r))
  // An accepted query starts the search in the next cycle.
  `PLI_ASSERT_NXT(a_query_start, in_acc && (in_req.kind == KIND_QUERY),
    state_r == ST_SRCH)
  // No request is taken while a result is pending.
  `PLI_ASSERT_IMP(a_no_overlap, out_res.valid, !in_req.ready)
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for piecewise_linear_interp_top: grid loads and
// interpolation queries over valid/ready channels, count changes over APB.
// Depends on pli_pkg, the channel interfaces in hdl/pli_if.sv and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import pli_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [5:0]  point_index;
    logic [31:0] coord;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] interp_value;
    logic        saturated;
  } res_t;

  localparam int NPTS = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  pli_req_if in_req();
  pli_res_if out_res();

  piecewise_linear_interp_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Predictor state: our own copy of the grid and of the count register.
  logic signed [31:0] grid_x[NPTS];
  logic signed [31:0] grid_y[NPTS];
  logic [6:0] point_count;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  longint cycle_count = 0;
  bit   no_idle = 1'b0;     // set to suppress random gaps on both sides
  bit   hold_results = 1'b0; // long stall on the result side
  int   hold_cycles = 0;

  // Interpolates at xq over the active grid, exactly as the block should.
  function automatic res_t interp_predict(logic signed [31:0] xq);
    int n, lo, hi, mid, right, left;
    logic signed [63:0] dx, dy, dt, sum, xlo;
    logic [63:0] mdx, mdy, mdt, q;
    logic neg;
    res_t r;
    n = point_count < 2 ? 2 : (point_count > NPTS ? NPTS : point_count);
    lo = 0; hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (grid_x[mid] < xq) lo = mid + 1;
      else hi = mid;
    end
    right = lo < 1 ? 1 : (lo > n - 1 ? n - 1 : lo);
    left = right - 1;
    xlo = grid_x[left];
    dx = 64'(grid_x[right]) - xlo;
    r.saturated = 1'b0;
    if (dx == 0) begin
      r.interp_value = grid_y[left];
      return r;
    end
    dy = 64'(grid_y[right]) - 64'(grid_y[left]);
    dt = 64'(xq) - xlo;
    mdx = dx < 0 ? -dx : dx;
    mdy = dy < 0 ? -dy : dy;
    mdt = dt < 0 ? -dt : dt;
    q = (mdy * mdt) / mdx;
    neg = (dx < 0) ^ (dy < 0) ^ (dt < 0);
    if (q >= (64'd1 << 40)) begin
      r.saturated = 1'b1;
      r.interp_value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return r;
    end
    sum = neg ? 64'(grid_y[left]) - $signed(q) : 64'(grid_y[left]) + $signed(q);
    if (sum > 64'sd2147483647) begin
      r.saturated = 1'b1; sum = 64'sd2147483647;
    end else if (sum < -64'sd2147483648) begin
      r.saturated = 1'b1; sum = -64'sd2147483648;
    end
    r.interp_value = sum[31:0];
    return r;
  endfunction

  // Driver: offers queued requests with random gaps. A request that is
  // offered and not yet taken keeps its valid and payload until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) void'(pending_reqs.pop_front());
      if (in_req.valid && !in_req.ready) begin
        // Still waiting for the block; everything stays as it is.
      end else if (pending_reqs.size() > 0 &&
                   (no_idle || $urandom_range(99) >= 19)) begin
        in_req.valid       <= 1'b1;
        in_req.kind        <= pending_reqs[0].kind;
        in_req.point_index <= pending_reqs[0].point_index;
        in_req.coord       <= pending_reqs[0].coord;
        in_req.value       <= pending_reqs[0].value;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // Prediction on each accepted request, in acceptance order.
  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) begin
      if (in_req.kind == KIND_LOAD) begin
        grid_x[in_req.point_index] = in_req.coord;
        grid_y[in_req.point_index] = in_req.value;
      end else begin
        expected_results.push_back(interp_predict(in_req.coord));
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_res.interp_value);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_res.interp_value !== want.interp_value) begin
          $error("interp_value expected %h actual %h",
                 want.interp_value, out_res.interp_value);
          errors++;
        end
        if (out_res.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, out_res.saturated);
          errors++;
        end
      end
    end
  end

  // Result-side ready: random stalls, plus a long counted hold-off on demand.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_results && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= no_idle || $urandom_range(99) >= 19;
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_req.valid || expected_results.size() != 0)
      @(posedge clk);
    // A trailing load may still be in flight, so the task waits on before it returns.
    repeat (100) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] n);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(4 * REG_SOURCE_COUNT); cfg_pwdata <= 32'(n);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    point_count = n;
  endtask

  task automatic push_load(int idx, logic [31:0] x, logic [31:0] y);
    req_t r;
    r.kind = KIND_LOAD; r.point_index = idx[5:0]; r.coord = x; r.value = y;
    pending_reqs.push_back(r);
  endtask

  task automatic push_query(logic [31:0] x);
    req_t r;
    r.kind = KIND_QUERY; r.point_index = 6'($urandom); r.coord = x;
    r.value = $urandom;
    pending_reqs.push_back(r);
  endtask

  // Loads a strictly increasing grid over all 64 slots so no read ever
  // touches an unwritten entry, whatever the count. Spacing is random.
  task automatic load_grid(int span_bits);
    int base;
    base = -(NPTS * (1 << span_bits)) / 2;
    for (int i = 0; i < NPTS; i++) begin
      base += 1 + $urandom_range((1 << span_bits) - 1);
      push_load(i, base, $urandom);
    end
  endtask

  function automatic logic [31:0] near_point(int n);
    int k;
    k = $urandom_range(n - 1);
    case ($urandom_range(3))
      0: return grid_x[k];
      1: return grid_x[k] + $signed($urandom_range(16)) - 8;
      2: return $urandom;
      default: return grid_x[k] + $signed($urandom_range(65535)) - 32768;
    endcase
  endfunction

  initial begin
    int n;
    in_req.kind = 1'b0; in_req.point_index = '0; in_req.coord = '0;
    in_req.value = '0; in_req.valid = 1'b0; out_res.ready = 1'b0;
    point_count = COUNT_RESET;
    foreach (grid_x[i]) begin
      grid_x[i] = 0; grid_y[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme coordinates and values, equal bracket coordinates,
    // extrapolation on both ends, and saturation in both directions.
    push_load(0, 32'h8000_0000, 32'h8000_0000);
    push_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h8000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0000_0000);
    push_load(0, 32'h0000_0000, 32'h7FFF_FFFF);
    push_load(1, 32'h0000_0001, 32'h8000_0000);
    push_query(32'h7FFF_FFFF);      // extrapolates far down: clips low
    push_query(32'h8000_0000);      // extrapolates far up: clips high
    push_load(1, 32'h0000_0000, 32'h1234_5678);
    push_query(32'h0001_0000);      // equal brackets give the left value
    push_load(0, 32'h0001_0000, 32'h0002_0000);
    push_load(1, 32'h0003_0000, 32'hFFFE_0000);
    push_query(32'h0002_0000);
    push_query(32'hFFFF_0000);
    push_query(32'h0005_8000);
    push_load(63, 32'h7FFF_FFFF, 32'h0);   // top slot written
    wait_drained();

    // Random phases across counts, extremes included. A long result stall
    // hits the second phase so the block fills and stops taking requests.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: n = 2;
        1: n = 64;
        2: n = 127;  // above the maximum: used as 64
        3: n = 0;    // below the minimum: used as 2
        default: n = $urandom_range(2, 64);
      endcase
      write_count(n[6:0]);
      no_idle = (phase == 5);
      load_grid(phase % 2 ? 24 : 10);
      wait_drained();
      hold_results = (phase == 1);
      for (int i = 0; i < 180; i++) begin
        if ($urandom_range(9) == 0)
          push_load($urandom_range(63), $urandom, $urandom); // breaks order
        else
          push_query(near_point(NPTS));
      end
      wait_drained();
      hold_results = 1'b0;
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
